### hdl/symmetric_prime_gap_detector_top_macros.svh
// Assertion macros of the symmetric prime gap detector checker
`ifndef SYMMETRIC_PRIME_GAP_DETECTOR_TOP_MACROS_SVH
`define SYMMETRIC_PRIME_GAP_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define SPGD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define SPGD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/spgd_pkg.sv
// Shared types, constants and sizing functions of the symmetric prime gap detector
package spgd_pkg;

	localparam int PRIME_W         = 64;
	localparam int GAP_W           = 16;
	localparam int COUNT_W         = 6;
	localparam int DEF_WINDOW_GAPS = 32;
	localparam int DEF_MIN_GAPS    = 15;
	localparam int QUEUE_DEPTH     = 2;

	typedef logic [PRIME_W-1:0] prime_t;
	typedef logic [GAP_W-1:0]   gap_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam gap_t GAP_MAX = '1;

	typedef struct packed {
		prime_t next_prime;
	} prime_word_t;

	typedef struct packed {
		prime_t start_prime;
		count_t prime_count;
		logic   last_of_run;
	} pattern_word_t;

	// Center gap, counted from the oldest gap
	function automatic int spgd_center(int window_gaps);
		return (window_gaps >> 1) - 1;
	endfunction

	// Number of reportable lengths per series (odd or even)
	function automatic int spgd_checks(int window_gaps, int min_gaps);
		int c;
		int hm;
		c  = (window_gaps >> 1) - 1;
		hm = min_gaps >> 1;
		return (c >= hm) ? (c - hm + 1) : 0;
	endfunction

	// Slot count, at least one so that vectors never collapse
	function automatic int spgd_slots(int window_gaps, int min_gaps);
		return (spgd_checks(window_gaps, min_gaps) > 0) ? spgd_checks(window_gaps, min_gaps) : 1;
	endfunction

endpackage

### hdl/spgd_stream_if.sv
// Valid/ready stream interface carrying one word per handshake
interface spgd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/spgd_front.sv
// Front end: keeps the gap and prime windows and classifies each full window
module spgd_front import spgd_pkg::*; #(
	parameter int WINDOW_GAPS = DEF_WINDOW_GAPS,
	parameter int MIN_GAPS    = DEF_MIN_GAPS,
	localparam int SLOTS      = spgd_slots(WINDOW_GAPS, MIN_GAPS),
	localparam int JOB_W      = 2 * SLOTS + SLOTS * PRIME_W
) (
	input  logic               clk,
	input  logic               arst_n,
	spgd_stream_if.sink        primes,
	output logic               push_valid,
	input  logic               push_ready,
	output logic [JOB_W-1:0]   push_data
);
	localparam int C         = spgd_center(WINDOW_GAPS);
	localparam int HM        = MIN_GAPS >> 1;
	localparam int NJ        = spgd_checks(WINDOW_GAPS, MIN_GAPS);
	localparam int MASK_W    = 2 * SLOTS;
	localparam int FILL_W    = $clog2(WINDOW_GAPS + 2);
	localparam int FILL_FULL = WINDOW_GAPS + 1;

	logic [FILL_W-1:0]             fill_q;
	gap_t                          gaps_q [WINDOW_GAPS];
	prime_t                        hist_q [WINDOW_GAPS+1];
	logic                          chk_s1;
	prime_t                        newest;
	prime_t                        diff;
	gap_t                          gap_new;
	logic                          accept;
	logic                          done;
	logic [C:0]                    run_o;
	logic [C:0]                    run_e;
	logic [MASK_W-1:0]             mask;
	logic [SLOTS-1:0][PRIME_W-1:0] starts;

	// Gap to the newest prime, zero when not ascending, saturated above 16 bits
	always_comb begin
		newest = hist_q[WINDOW_GAPS];
		diff   = primes.data.next_prime - newest;
		if (primes.data.next_prime <= newest) begin
			gap_new = '0;
		end else if (|diff[PRIME_W-1:GAP_W]) begin
			gap_new = GAP_MAX;
		end else begin
			gap_new = diff[GAP_W-1:0];
		end
	end

	// Mirror compares around the center; a mismatch ends each series
	always_comb begin
		run_o[0] = 1'b1;
		for (int j = 1; j <= C; j++) begin
			run_o[j] = run_o[j-1] && (gaps_q[C-j] == gaps_q[C+j]);
		end
		run_e[0] = (gaps_q[C] == gaps_q[C+1]);
		for (int j = 1; j <= C; j++) begin
			run_e[j] = run_e[j-1] && (gaps_q[C-j] == gaps_q[C+1+j]);
		end
	end

	// Pick the reportable lengths and their start primes
	always_comb begin
		mask   = '0;
		starts = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (k < NJ) begin
				mask[k]         = run_o[HM+k];
				mask[SLOTS+k]   = run_e[HM+k];
				starts[k]       = hist_q[C-HM-k];
			end
		end
	end

	// Hand off only windows with matches; hold the window while the queue is full
	assign push_valid   = chk_s1 && (|mask);
	assign push_data    = {mask, starts};
	assign done         = !(|mask) || push_ready;
	assign primes.ready = !chk_s1 || done;
	assign accept       = primes.valid && primes.ready;

	// Advance fill count and classification flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			chk_s1 <= 1'b0;
		end else if (accept) begin
			if (fill_q != FILL_W'(FILL_FULL)) begin
				fill_q <= fill_q + 1'b1;
			end
			chk_s1 <= (fill_q >= FILL_W'(WINDOW_GAPS));
		end else if (done) begin
			chk_s1 <= 1'b0;
		end
	end

	// Shift the windows, oldest at index zero
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < WINDOW_GAPS; k++) begin
				hist_q[k] <= hist_q[k+1];
			end
			hist_q[WINDOW_GAPS] <= primes.data.next_prime;
			if (fill_q != '0) begin
				for (int k = 0; k < WINDOW_GAPS - 1; k++) begin
					gaps_q[k] <= gaps_q[k+1];
				end
				gaps_q[WINDOW_GAPS-1] <= gap_new;
			end
		end
	end

endmodule

### hdl/spgd_queue.sv
// Short first-in first-out queue between the front and back ends
module spgd_queue import spgd_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != (AW+1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hdl/spgd_back.sv
// Back end: serializes the matches of one window into result words
module spgd_back import spgd_pkg::*; #(
	parameter int WINDOW_GAPS = DEF_WINDOW_GAPS,
	parameter int MIN_GAPS    = DEF_MIN_GAPS,
	localparam int SLOTS      = spgd_slots(WINDOW_GAPS, MIN_GAPS),
	localparam int JOB_W      = 2 * SLOTS + SLOTS * PRIME_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  logic [JOB_W-1:0] pop_data,
	spgd_stream_if.source    patterns
);
	localparam int HM     = MIN_GAPS >> 1;
	localparam int MASK_W = 2 * SLOTS;

	logic [MASK_W-1:0]             mask_q;
	logic [SLOTS-1:0][PRIME_W-1:0] starts_q;
	logic                          out_valid_q;
	pattern_word_t                 out_word_q;
	logic [MASK_W-1:0]             pop_mask;
	logic [SLOTS-1:0][PRIME_W-1:0] pop_starts;
	logic [MASK_W-1:0]             low;
	logic [MASK_W-1:0]             rest;
	logic                          has;
	logic                          take;
	logic                          load;
	prime_t                        sel_prime;
	count_t                        sel_count;

	assign pop_mask   = pop_data[JOB_W-1 -: MASK_W];
	assign pop_starts = pop_data[SLOTS*PRIME_W-1:0];

	// Take the lowest pending match: odd lengths first, each series short to long
	assign has  = |mask_q;
	assign low  = mask_q & (~mask_q + 1'b1);
	assign rest = mask_q & ~low;
	assign take = has && (!out_valid_q || patterns.ready);

	// Load the next window once the current one is drained
	assign pop_ready = !has || (take && !(|rest));
	assign load      = pop_valid && pop_ready;

	// Select start prime and prime count of the chosen match
	always_comb begin
		sel_prime = '0;
		sel_count = '0;
		for (int k = 0; k < SLOTS; k++) begin
			sel_prime = sel_prime | ({PRIME_W{low[k] | low[SLOTS+k]}} & starts_q[k]);
			sel_count = sel_count | ({COUNT_W{low[k]}} & COUNT_W'(2 * (HM + k) + 2));
			sel_count = sel_count | ({COUNT_W{low[SLOTS+k]}} & COUNT_W'(2 * (HM + k) + 3));
		end
	end

	assign patterns.valid = out_valid_q;
	assign patterns.data  = out_word_q;

	// Advance pending matches and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= pop_mask;
			end else if (take) begin
				mask_q <= rest;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (patterns.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold window primes and the output word
	always_ff @(posedge clk) begin
		if (load) begin
			starts_q <= pop_starts;
		end
		if (take) begin
			out_word_q.start_prime <= sel_prime;
			out_word_q.prime_count <= sel_count;
			out_word_q.last_of_run <= !(|rest);
		end
	end

endmodule

### hdl/symmetric_prime_gap_detector_top.sv
// Accepts one prime per cycle unless stalled; the window shifts on acceptance.
// Results pass the check flag, the queue, the match mask and the output register;
// one prime's results leave it one per cycle when not stalled, odd lengths first.
// A two-entry queue between window and result stage lets primes keep flowing;
// input stalls only when that queue is full and a classified window matched.
// Reset clears fill count, flags and queue; no result before WINDOW_GAPS+1 primes.
module symmetric_prime_gap_detector_top import spgd_pkg::*; #(
	parameter int WINDOW_GAPS = DEF_WINDOW_GAPS,
	parameter int MIN_GAPS    = DEF_MIN_GAPS
) (
	input  logic          clk,
	input  logic          arst_n,
	spgd_stream_if.sink   primes,
	spgd_stream_if.source patterns
);
	localparam int SLOTS = spgd_slots(WINDOW_GAPS, MIN_GAPS);
	localparam int JOB_W = 2 * SLOTS + SLOTS * PRIME_W;

	logic             push_valid;
	logic             push_ready;
	logic [JOB_W-1:0] push_data;
	logic             pop_valid;
	logic             pop_ready;
	logic [JOB_W-1:0] pop_data;

	spgd_front #(
		.WINDOW_GAPS(WINDOW_GAPS),
		.MIN_GAPS   (MIN_GAPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.primes    (primes),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	spgd_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	spgd_back #(
		.WINDOW_GAPS(WINDOW_GAPS),
		.MIN_GAPS   (MIN_GAPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.patterns (patterns)
	);

endmodule

### hdl/spgd_checker.sv
// Port-level checker of the symmetric prime gap detector and its bind
`include "symmetric_prime_gap_detector_top_macros.svh"

module spgd_checker import spgd_pkg::*; #(
	parameter int WINDOW_GAPS = DEF_WINDOW_GAPS,
	parameter int MIN_GAPS    = DEF_MIN_GAPS
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input pattern_word_t out_word
);
	localparam int SEEN_W    = $clog2(WINDOW_GAPS + 2);
	localparam int C         = spgd_center(WINDOW_GAPS);
	localparam int LO_COUNT  = 2 * (MIN_GAPS >> 1) + 2;
	localparam bit NO_WRAP   = (2 * C + 3) < (1 << COUNT_W);

	logic [SEEN_W-1:0] seen_q;

	// Count accepted primes up to a full window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (in_valid && in_ready && (seen_q != SEEN_W'(WINDOW_GAPS + 1))) begin
			seen_q <= seen_q + 1'b1;
		end
	end

	`SPGD_ASSERT_IMPL(a_no_early_result, out_valid, seen_q == SEEN_W'(WINDOW_GAPS + 1), "result before the window filled")
	`SPGD_ASSERT_IMPL(a_count_floor, out_valid && NO_WRAP, out_word.prime_count >= COUNT_W'(LO_COUNT), "prime count below the minimum pattern")
	`SPGD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stalled result word changed")

endmodule

bind symmetric_prime_gap_detector_top spgd_checker #(
	.WINDOW_GAPS(WINDOW_GAPS),
	.MIN_GAPS   (MIN_GAPS)
) u_spgd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (primes.valid),
	.in_ready (primes.ready),
	.out_valid(patterns.valid),
	.out_ready(patterns.ready),
	.out_word (patterns.data)
);

### bench/symmetric_prime_gap_detector_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the symmetric prime gap detector with gap-pattern stimulus
module symmetric_prime_gap_detector_top_tb;
	import spgd_pkg::*;

	localparam int WINDOW       = DEF_WINDOW_GAPS;
	localparam int MIN_LEN      = DEF_MIN_GAPS;
	localparam int CENTER       = WINDOW / 2 - 1;
	localparam int HALF_MIN     = MIN_LEN / 2;
	localparam int RANDOM_ITEMS = 340;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	// Window predictor plus the queue of pattern words it predicts
	class pattern_scoreboard;
		gap_t          gaps [WINDOW];
		prime_t        recent [WINDOW + 1];
		int            fill;
		int            oldest;
		pattern_word_t expected [$];
		int            errors;

		function new();
			fill   = 0;
			oldest = 0;
			errors = 0;
		endfunction

		function gap_t gap_from_oldest(int m);
			return gaps[(oldest + m) % WINDOW];
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Shift the prime into the window and predict the patterns it reveals
		function void note_prime(prime_t p);
			prime_t        prev;
			prime_t        diff;
			gap_t          g;
			pattern_word_t found [$];
			pattern_word_t w;
			if (fill == 0) begin
				recent[0] = p;
				fill = 1;
				return;
			end
			prev = (fill <= WINDOW) ? recent[fill - 1] : recent[WINDOW];
			diff = (p > prev) ? p - prev : '0;
			g    = (diff > prime_t'(GAP_MAX)) ? GAP_MAX : diff[GAP_W-1:0];
			if (fill < WINDOW + 1) begin
				gaps[fill - 1] = g;
				recent[fill] = p;
				fill++;
				if (fill < WINDOW + 1)
					return;
			end else begin
				gaps[oldest] = g;
				oldest = (oldest + 1) % WINDOW;
				for (int k = 0; k < WINDOW; k++)
					recent[k] = recent[k + 1];
				recent[WINDOW] = p;
			end
			// odd lengths: centered on one gap
			for (int j = 1; j <= CENTER; j++) begin
				if (gap_from_oldest(CENTER - j) != gap_from_oldest(CENTER + j))
					break;
				if (j >= HALF_MIN) begin
					w.start_prime = recent[CENTER - j];
					w.prime_count = count_t'(2 * j + 2);
					w.last_of_run = 1'b0;
					found = {found, w};
				end
			end
			// even lengths: centered between two gaps
			for (int j = 0; j <= CENTER; j++) begin
				if (gap_from_oldest(CENTER - j) != gap_from_oldest(CENTER + 1 + j))
					break;
				if (j >= HALF_MIN) begin
					w.start_prime = recent[CENTER - j];
					w.prime_count = count_t'(2 * j + 3);
					w.last_of_run = 1'b0;
					found = {found, w};
				end
			end
			if (found.size() > 0)
				found[found.size() - 1].last_of_run = 1'b1;
			expected = {expected, found};
		endfunction

		// Compare one pattern word against the oldest prediction
		function void check_pattern(pattern_word_t got);
			pattern_word_t want;
			if (expected.size() == 0) begin
				$error("unexpected pattern word: start_prime %0d, prime_count %0d, last_of_run %0b",
					got.start_prime, got.prime_count, got.last_of_run);
				errors++;
				return;
			end
			want = expected.pop_front();
			if (got.start_prime !== want.start_prime) begin
				$error("start_prime: expected %0d, actual %0d", want.start_prime, got.start_prime);
				errors++;
			end
			if (got.prime_count !== want.prime_count) begin
				$error("prime_count: expected %0d, actual %0d", want.prime_count, got.prime_count);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0b, actual %0b", want.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	spgd_stream_if #(.payload_t(prime_word_t))   prime_stream ();
	spgd_stream_if #(.payload_t(pattern_word_t)) pattern_stream ();

	symmetric_prime_gap_detector_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.primes   (prime_stream),
		.patterns (pattern_stream)
	);

	pattern_scoreboard sb = new();

	prime_t      cur;
	int          sent;
	bit          calm;
	bit          hold_req;
	int          hold_left;
	int unsigned cycle_count;

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drive ready: random stalls, quiet stretches, one long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pattern_stream.ready <= 1'b0;
		end else begin
			pattern_stream.ready <= calm || ($urandom_range(99) >= 9);
		end
	end

	// Check every accepted pattern word
	always @(posedge clk) begin
		if (arst_n && pattern_stream.valid && pattern_stream.ready)
			sb.check_pattern(pattern_stream.data);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Offer one prime, with random idle cycles ahead of it, until accepted
	task automatic send_prime(prime_t p);
		while (!calm && $urandom_range(99) < 9) begin
			prime_stream.valid <= 1'b0;
			@(negedge clk);
		end
		prime_stream.valid <= 1'b1;
		prime_stream.data  <= '{next_prime: p};
		do
			@(posedge clk);
		while (!prime_stream.ready);
		sb.note_prime(p);
		sent++;
		@(negedge clk);
	endtask

	// Advance by a gap; a zero gap repeats or steps back
	task automatic feed_gap(prime_t g);
		if (g == 0) begin
			if ($urandom_range(1) && cur > 1000)
				cur = cur - $urandom_range(1, 1000);
		end else begin
			cur = cur + g;
		end
		send_prime(cur);
	endtask

	// Hold the input low until every predicted word has come out
	task automatic pause_until_drained();
		prime_stream.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic prime_t rand_gap();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return prime_t'(2 * $urandom_range(1, 3));
			6:                return '0;
			7:                return prime_t'($urandom_range(1, 65535));
			8:                return prime_t'(65535) + prime_t'($urandom_range(1, 1 << 20));
			default:          return prime_t'($urandom_range(7, 40));
		endcase
	endfunction

	// Feed a gap palindrome over a small alphabet, now and then broken
	task automatic feed_palindrome();
		prime_t symbols [3];
		prime_t half [$];
		int     len;
		int     kinds;
		bit     odd_center;
		bit     broken;
		len        = $urandom_range(1, 16);
		kinds      = $urandom_range(1, 3);
		odd_center = $urandom_range(1);
		broken     = ($urandom_range(4) == 0);
		for (int i = 0; i < kinds; i++)
			symbols[i] = rand_gap();
		for (int i = 0; i < len; i++)
			half = {half, symbols[$urandom_range(kinds - 1)]};
		foreach (half[i])
			feed_gap(half[i]);
		if (odd_center)
			feed_gap(symbols[$urandom_range(kinds - 1)]);
		for (int i = len - 1; i >= 0; i--)
			feed_gap((broken && i == len / 2) ? half[i] + 2 : half[i]);
	endtask

	// Feed a run of equal gaps; a window filled by the run reports all lengths
	task automatic feed_run();
		prime_t g;
		int     n;
		g = rand_gap();
		n = $urandom_range(8, 40);
		repeat (n)
			feed_gap(g);
	endtask

	// Feed a few unrelated gaps and wide jumps
	task automatic feed_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			if ($urandom_range(3) == 0) begin
				cur = {$urandom, $urandom};
				send_prime(cur);
			end else begin
				feed_gap(rand_gap());
			end
		end
	endtask

	initial begin
		int  start;
		bit  mid_pause_done;
		arst_n               = 1'b0;
		prime_stream.valid   = 1'b0;
		prime_stream.data    = '0;
		pattern_stream.ready = 1'b0;
		calm                 = 1'b0;
		hold_req             = 1'b0;
		hold_left            = 0;
		sent                 = 0;
		cycle_count          = 0;
		cur                  = '0;
		mid_pause_done       = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Fill the window; nothing may come out before it is full
		cur = 2;
		send_prime(cur);
		cur = 3;
		send_prime(cur);
		repeat (WINDOW - 1)
			feed_gap(2);

		// Hold off the receiver while equal gaps flood the result path
		hold_req = 1'b1;
		repeat (10)
			feed_gap(2);
		pause_until_drained();

		// Top of the range, repeat, step back, and saturating gaps
		cur = 64'hFFFF_FFFF_FFFF_FF00;
		send_prime(cur);
		cur = 64'hFFFF_FFFF_FFFF_FFFF;
		send_prime(cur);
		send_prime(cur);
		cur = 5;
		send_prime(cur);
		feed_gap(65535);
		feed_gap(65536);
		feed_gap(1000000);
		feed_gap(prime_t'(1) << 40);
		pause_until_drained();

		// Random part: mostly palindromes, some runs and noise
		start = sent;
		while (sent - start < RANDOM_ITEMS) begin
			calm = (sent - start >= 120) && (sent - start < 180);
			if (!mid_pause_done && sent - start >= RANDOM_ITEMS / 2) begin
				pause_until_drained();
				mid_pause_done = 1'b1;
			end
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: feed_palindrome();
				6:                feed_run();
				default:          feed_noise();
			endcase
		end
		calm = 1'b0;
		prime_stream.valid <= 1'b0;

		// Drain, then watch a little longer for stray words
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
